// ----- src/cctr_pkg.sv -----
// shared types, constants and direction tables for the circle chain code tracer
`default_nettype none

package cctr_pkg;

	typedef logic [3:0] dir_t;

	localparam dir_t DIR_NONE = 4'd0;
	localparam dir_t DIR_W    = 4'd1;
	localparam dir_t DIR_NW   = 4'd2;
	localparam dir_t DIR_N    = 4'd3;
	localparam dir_t DIR_NE   = 4'd4;
	localparam dir_t DIR_E    = 4'd5;
	localparam dir_t DIR_SE   = 4'd6;
	localparam dir_t DIR_S    = 4'd7;
	localparam dir_t DIR_SW   = 4'd8;

	localparam logic REG_CIRCLE_RADIUS = 1'b0;
	localparam logic REG_ROW_WIDTH     = 1'b1;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;

	// square root of (x*x + y*y) * 2^24, one result bit per cycle
	localparam int RAD_W      = 22;
	localparam int ROOT_W     = 23;
	localparam int REM_W      = 25;
	localparam int SQRT_STEPS = 23;
	localparam int CNT_W      = 5;

	typedef logic [ROOT_W-1:0] root_t;

	function automatic logic signed [1:0] dir_dx(input dir_t d);
		logic signed [1:0] v;
		case (d) inside
			DIR_W, DIR_NW, DIR_SW: v = -2'sd1;
			DIR_NE, DIR_E, DIR_SE: v = 2'sd1;
			default:               v = 2'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [1:0] dir_dy(input dir_t d);
		logic signed [1:0] v;
		case (d) inside
			DIR_NW, DIR_N, DIR_NE: v = -2'sd1;
			DIR_SE, DIR_S, DIR_SW: v = 2'sd1;
			default:               v = 2'sd0;
		endcase
		return v;
	endfunction

	// fixed sequence for the unit circle
	function automatic dir_t unit_seq(input logic [2:0] i);
		dir_t v;
		case (i) inside
			3'd1, 3'd2: v = DIR_E;
			3'd3, 3'd4: v = DIR_S;
			3'd5, 3'd6: v = DIR_W;
			default:    v = DIR_N;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- src/circle_chain_code_tracer.sv -----
// top level: traces a digital circle with 8-neighbour chain code, one step per input word
// radius 2 and up: a word runs PREP, ROOT, ERR, PICK and HOLD before the next is taken
// ROOT waits for three bit-serial square roots side by side; result valid once HOLD is left
// radius 1: PREP goes straight to PICK, no square roots
// one output register; a new word is taken while the last result waits
// arst_n clears radius and row width to 1 and puts the trace at (-1,0) with no step taken
`default_nettype none

module circle_chain_code_tracer
	import cctr_pkg::*;
#(
	parameter int MAX_RADIUS = 511
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,
	input  wire logic [15:0]            cfg_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // restart
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // direction, pixel_offset, step_index
	output logic                        m_axis_tlast   // last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_ERR  = 3'd3;
	localparam logic [2:0] ST_PICK = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	function automatic logic [8:0] clamp_radius(input logic [8:0] r);
		logic [9:0] rmax;
		logic [8:0] v;
		rmax = 10'(MAX_RADIUS);
		if (r == 9'd0) begin
			v = 9'd1;
		end else if ({1'b0, r} > rmax) begin
			v = rmax[8:0];
		end else begin
			v = r;
		end
		return v;
	endfunction

	function automatic logic signed [17:0] offset_of(input dir_t d, input logic [15:0] w);
		logic signed [17:0] wx;
		logic signed [17:0] v;
		wx = $signed({2'b00, w});
		case (d)
			DIR_W:   v = -18'sd1;
			DIR_NW:  v = -wx - 18'sd1;
			DIR_N:   v = -wx;
			DIR_NE:  v = -wx + 18'sd1;
			DIR_E:   v = 18'sd1;
			DIR_SE:  v = wx + 18'sd1;
			DIR_S:   v = wx;
			default: v = wx - 18'sd1;
		endcase
		return v;
	endfunction

	logic [2:0]         state_q;
	logic [8:0]         radius_q;
	logic [15:0]        width_q;
	logic [10:0]        pos_x_q;
	logic [10:0]        pos_y_q;
	dir_t               prev_q;
	logic [11:0]        count_q;
	logic               out_valid_q;

	dir_t               cand_q [3];
	logic               first_q;
	root_t              err_q [3];
	dir_t               res_dir_q;
	logic signed [17:0] res_off_q;
	logic [11:0]        res_idx_q;
	logic               res_last_q;
	dir_t               out_dir_q;
	logic signed [17:0] out_off_q;
	logic [11:0]        out_idx_q;
	logic               out_last_q;

	logic [8:0]         eff_r;
	logic [10:0]        start_x;
	logic [10:0]        cfg_start_x;
	logic               at_start;
	logic               do_start;
	logic               r_one;
	logic               in_acc;
	logic               out_free;
	logic               first;
	dir_t               cand_d [3];
	logic [RAD_W-1:0]   rad [3];
	root_t              root [3];
	logic [2:0]         done;
	root_t              tgt;
	dir_t               pick_dir;
	root_t              best_e;
	logic signed [1:0]  pick_dx;
	logic signed [1:0]  pick_dy;
	logic [10:0]        nx;
	logic [10:0]        ny;

	assign eff_r       = clamp_radius(radius_q);
	assign start_x     = 11'd0 - {2'b00, eff_r};
	assign cfg_start_x = 11'd0 - {2'b00, clamp_radius(cfg_data[8:0])};
	assign at_start    = (pos_x_q == start_x) && (pos_y_q == 11'd0);
	assign do_start    = s_axis_tdata[0] || (prev_q == DIR_NONE) || (prev_q > DIR_SW) ||
	                     (at_start && (count_q != 12'd0));
	assign r_one       = eff_r == 9'd1;
	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign out_free    = !out_valid_q || m_axis_tready;
	assign first       = (count_q == 12'd0) && (prev_q == DIR_NONE);
	assign tgt         = {2'b00, eff_r, 12'd0};

	always_comb begin
		cand_d[0] = first ? DIR_N : ((prev_q == DIR_W) ? DIR_SW : prev_q - 4'd1);
		cand_d[1] = first ? DIR_NE : prev_q;
		cand_d[2] = (prev_q == DIR_SW) ? DIR_W : prev_q + 4'd1;
	end

	// candidate squared distances and one root unit per candidate
	for (genvar k = 0; k < 3; k++) begin : g_cand
		logic signed [11:0] cx;
		logic signed [11:0] cy;
		logic signed [23:0] sqx;
		logic signed [23:0] sqy;
		logic signed [1:0]  dx;
		logic signed [1:0]  dy;

		assign dx  = dir_dx(cand_d[k]);
		assign dy  = dir_dy(cand_d[k]);
		assign cx  = $signed({pos_x_q[10], pos_x_q}) + {{10{dx[1]}}, dx};
		assign cy  = $signed({pos_y_q[10], pos_y_q}) + {{10{dy[1]}}, dy};
		assign sqx = cx * cx;
		assign sqy = cy * cy;
		assign rad[k] = sqx[RAD_W-1:0] + sqy[RAD_W-1:0];

		cctr_isqrt u_isqrt (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    ((state_q == ST_PREP) && !r_one),
			.radicand (rad[k]),
			.done     (done[k]),
			.root     (root[k])
		);
	end

	always_comb begin
		pick_dir = cand_q[0];
		best_e   = err_q[0];
		if (err_q[1] < best_e) begin
			pick_dir = cand_q[1];
			best_e   = err_q[1];
		end
		if (!first_q && (err_q[2] < best_e)) begin
			pick_dir = cand_q[2];
		end
		if (r_one) begin
			pick_dir = unit_seq(count_q[2:0]);
		end
		pick_dx = dir_dx(pick_dir);
		pick_dy = dir_dy(pick_dir);
		nx = pos_x_q + {{9{pick_dx[1]}}, pick_dx};
		ny = pos_y_q + {{9{pick_dy[1]}}, pick_dy};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radius_q    <= 9'd1;
			width_q     <= 16'd1;
			pos_x_q     <= 11'h7ff;
			pos_y_q     <= 11'd0;
			prev_q      <= DIR_NONE;
			count_q     <= 12'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CIRCLE_RADIUS: begin
						radius_q <= cfg_data[8:0];
						pos_x_q  <= cfg_start_x;
						pos_y_q  <= 11'd0;
						prev_q   <= DIR_NONE;
						count_q  <= 12'd0;
					end
					REG_ROW_WIDTH: begin
						width_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end

			if ((state_q == ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (do_start) begin
							pos_x_q <= start_x;
							pos_y_q <= 11'd0;
							prev_q  <= DIR_NONE;
							count_q <= 12'd0;
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= r_one ? ST_PICK : ST_ROOT;
				end
				ST_ROOT: begin
					if (&done) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					pos_x_q <= nx;
					pos_y_q <= ny;
					prev_q  <= pick_dir;
					if (count_q != 12'hfff) begin
						count_q <= count_q + 12'd1;
					end
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			cand_q  <= cand_d;
			first_q <= first;
		end
		if (state_q == ST_ERR) begin
			for (int k = 0; k < 3; k++) begin
				err_q[k] <= (root[k] > tgt) ? root[k] - tgt : tgt - root[k];
			end
		end
		if (state_q == ST_PICK) begin
			res_dir_q  <= pick_dir;
			res_off_q  <= offset_of(pick_dir, width_q);
			res_idx_q  <= (count_q != 12'hfff) ? count_q + 12'd1 : count_q;
			res_last_q <= (nx == start_x) && (ny == 11'd0);
		end
		if ((state_q == ST_HOLD) && out_free) begin
			out_dir_q  <= res_dir_q;
			out_off_q  <= res_off_q;
			out_idx_q  <= res_idx_q;
			out_last_q <= res_last_q;
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_idx_q, out_off_q, out_dir_q};
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- src/cctr_isqrt.sv -----
// bit-serial integer square root of a radicand followed by 24 zero bits
`default_nettype none

module cctr_isqrt
	import cctr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [RAD_W-1:0] radicand,
	output logic                  done,
	output root_t                 root
);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	root_t            root_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W+1:0] shifted;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             fits;

	always_comb begin
		shifted = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		fits    = shifted >= trial;
		diff    = shifted - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SQRT_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = cnt_q == '0;
	assign root = root_q;

endmodule

`default_nettype wire

// ----- src/cctr_checker.sv -----
// port-level checks for the circle chain code tracer, bound to the top level
`default_nettype none

module cctr_checker
	import cctr_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   m_axis_tlast
);

	// one word at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a step is at work");

	a_direction_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3:0] != DIR_NONE) && (m_axis_tdata[3:0] <= DIR_SW))
		else $error("direction code out of range");

	a_step_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[33:22] != 12'd0)
		else $error("step index zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output word changed");

endmodule

bind circle_chain_code_tracer cctr_checker u_cctr_checker (.*);

`default_nettype wire
